// ===== src/dit_pkg.sv =====
// Shared types, constants and helpers of the decimal integer tokenizer.
package dit_pkg;

  localparam int unsigned ValueBits  = 32;
  localparam int unsigned NumBits    = 32;
  localparam int unsigned MaxResults = 3;
  localparam int unsigned CntBits    = 2;
  localparam int unsigned SumBits    = ValueBits + 4;

  localparam logic [ValueBits-1:0] HalfRange = {1'b1, {(ValueBits-1){1'b0}}};

  localparam logic [7:0] CharLf        = 8'd10;
  localparam logic [7:0] CharCr        = 8'd13;
  localparam logic [7:0] CharMinus     = 8'd45;
  localparam logic [7:0] CharDot       = 8'd46;
  localparam logic [7:0] CharSlash     = 8'd47;
  localparam logic [7:0] CharZero      = 8'd48;
  localparam logic [7:0] CharNine      = 8'd57;
  localparam logic [7:0] BlankLimit    = 8'd42;
  localparam logic [7:0] CommentReset  = 8'd35;

  typedef enum logic [2:0] {
    PhSeek    = 3'd0,
    PhDigits  = 3'd1,
    PhToken   = 3'd2,
    PhBlank   = 3'd3,
    PhComment = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KindInt = 2'd0,
    KindEol = 2'd1,
    KindEnd = 2'd2
  } kind_e;

  typedef enum logic [0:0] {
    CfgCommentChar = 1'b0,
    CfgLineMode    = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] value;
    logic               ovf;
    logic               run_end;
  } result_t;

  typedef struct packed {
    phase_e                 phase;
    logic [ValueBits-1:0]   acc;
    logic                   neg;
    logic                   ovf;
  } scan_state_t;

  typedef struct packed {
    logic [7:0] comment_char;
    logic       line_mode;
  } cfg_t;

  function automatic result_t num_result(logic [ValueBits-1:0] acc, logic neg, logic ovf);
    result_t                     r;
    logic signed [ValueBits-1:0] sv;
    sv        = neg ? signed'(-acc) : signed'(acc);
    r.kind    = KindInt;
    r.value   = NumBits'(sv);
    r.ovf     = ovf | (!neg && (acc == HalfRange));
    r.run_end = 1'b0;
    return r;
  endfunction

endpackage

// ===== src/dit_ifs.sv =====
// Handshake interfaces: byte input, result output and register write.
interface dit_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface dit_out_if;
  import dit_pkg::*;
  logic               valid;
  logic               ready;
  kind_e              result_kind;
  logic signed [31:0] number_value;
  logic               overflowed;
  logic               run_end;

  modport source (output valid, output result_kind, output number_value, output overflowed,
                  output run_end, input ready);
  modport sink   (input valid, input result_kind, input number_value, input overflowed,
                  input run_end, output ready);
endinterface

interface dit_cfg_if;
  import dit_pkg::*;
  logic       valid;
  logic       ready;
  cfg_reg_e   index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/dit_scan.sv =====
// Next-state and result logic for one text byte.
module dit_scan (
  input  dit_pkg::scan_state_t               state_i,
  input  dit_pkg::cfg_t                      cfg_i,
  input  logic [7:0]                         text_byte_i,
  input  logic                               final_byte_i,
  output dit_pkg::scan_state_t               state_o,
  output dit_pkg::result_t                   res_o [dit_pkg::MaxResults],
  output logic [dit_pkg::CntBits-1:0]        count_o
);
  import dit_pkg::*;

  logic                 is_nl;
  logic                 is_digit;
  logic [3:0]           dig;
  logic [SumBits-1:0]   acc_ext;
  logic [SumBits-1:0]   sum;
  scan_state_t          seek_st;
  logic                 seek_emit;
  result_t              seek_res;
  scan_state_t          nxt;
  logic                 do_tail;
  logic                 do_seek;
  logic                 from_blank;
  logic [3:0]           flag;
  result_t              cand [4];
  result_t              res [MaxResults];
  logic [CntBits-1:0]   idx;

  assign is_nl    = (text_byte_i == CharLf) || (text_byte_i == CharCr);
  assign is_digit = (text_byte_i >= CharZero) && (text_byte_i <= CharNine);
  assign dig      = 4'(text_byte_i - CharZero);
  assign acc_ext  = SumBits'(state_i.acc);
  assign sum      = (acc_ext << 3) + (acc_ext << 1) + SumBits'(dig);

  // outcome of a byte seen while looking for a number start
  always_comb begin
    seek_st          = state_i;
    seek_st.phase    = PhSeek;
    seek_emit        = 1'b0;
    seek_res.kind    = KindEol;
    seek_res.value   = '0;
    seek_res.ovf     = 1'b0;
    seek_res.run_end = 1'b0;
    if (is_nl) begin
      seek_emit = cfg_i.line_mode;
    end else if (text_byte_i == CharMinus) begin
      seek_st.phase = PhDigits;
      seek_st.acc   = '0;
      seek_st.neg   = 1'b1;
      seek_st.ovf   = 1'b0;
    end else if (is_digit) begin
      seek_st.phase = PhDigits;
      seek_st.acc   = ValueBits'(dig);
      seek_st.neg   = 1'b0;
      seek_st.ovf   = 1'b0;
    end else if ((text_byte_i == CharDot) || (text_byte_i == CharSlash)) begin
      seek_emit     = 1'b1;
      seek_res.kind = KindInt;
      seek_st.phase = PhToken;
    end
  end

  always_comb begin
    nxt        = state_i;
    flag       = '0;
    do_tail    = 1'b0;
    do_seek    = 1'b0;
    from_blank = 1'b0;
    unique case (state_i.phase)
      PhDigits: begin
        if (is_digit) begin
          nxt.acc = sum[ValueBits-1:0];
          if (!state_i.ovf && (sum > SumBits'(HalfRange))) begin
            nxt.ovf = 1'b1;
          end
        end else begin
          flag[0] = 1'b1;
          do_tail = 1'b1;
        end
      end
      PhToken: do_tail = 1'b1;
      PhBlank: begin
        do_tail    = 1'b1;
        from_blank = 1'b1;
      end
      PhComment: do_seek = is_nl;
      default: do_seek = 1'b1;
    endcase

    if (do_tail) begin
      priority if (is_nl) begin
        do_seek = 1'b1;
      end else if (text_byte_i == cfg_i.comment_char) begin
        nxt.phase = PhComment;
      end else if (text_byte_i < BlankLimit) begin
        nxt.phase = PhBlank;
      end else if (from_blank) begin
        do_seek = 1'b1;
      end else begin
        nxt.phase = PhToken;
      end
    end

    if (do_seek) begin
      nxt     = seek_st;
      flag[1] = seek_emit;
    end

    cand[0]         = num_result(state_i.acc, state_i.neg, state_i.ovf);
    cand[1]         = seek_res;
    cand[2]         = num_result(nxt.acc, nxt.neg, nxt.ovf);
    cand[3].kind    = KindEnd;
    cand[3].value   = '0;
    cand[3].ovf     = 1'b0;
    cand[3].run_end = 1'b0;

    if (final_byte_i) begin
      flag[2]   = (nxt.phase == PhDigits);
      flag[3]   = 1'b1;
      nxt.phase = PhSeek;
      nxt.acc   = '0;
      nxt.neg   = 1'b0;
      nxt.ovf   = 1'b0;
    end
  end

  // pack the emitted results in order
  always_comb begin
    idx = '0;
    for (int k = 0; k < MaxResults; k++) begin
      res[k] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      if (flag[i] && (idx < CntBits'(MaxResults))) begin
        res[idx] = cand[i];
        idx      = idx + 1'b1;
      end
    end
    for (int k = 0; k < MaxResults; k++) begin
      res[k].run_end = ((CntBits'(k) + 1'b1) == idx);
    end
  end

  assign state_o = nxt;
  assign res_o   = res;
  assign count_o = idx;

endmodule

// ===== src/dit_outbuf.sv =====
// Result buffer of up to three items drained one per cycle while the output is ready.
module dit_outbuf (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic [dit_pkg::CntBits-1:0]    count_i,
  input  dit_pkg::result_t               res_i [dit_pkg::MaxResults],
  output logic                           free_o,
  dit_out_if.source                      out_o
);
  import dit_pkg::*;

  result_t            slot_q [MaxResults];
  result_t            slot_d [MaxResults];
  logic [CntBits-1:0] cnt_q;
  logic [CntBits-1:0] cnt_d;
  logic               pop;

  assign pop    = out_o.valid && out_o.ready;
  assign free_o = (cnt_q == '0) || ((cnt_q == CntBits'(1)) && out_o.ready);

  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (load_i) begin
      slot_d = res_i;
      cnt_d  = count_i;
    end else if (pop) begin
      for (int k = 0; k < MaxResults - 1; k++) begin
        slot_d[k] = slot_q[k+1];
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign out_o.valid        = (cnt_q != '0);
  assign out_o.result_kind  = slot_q[0].kind;
  assign out_o.number_value = slot_q[0].value;
  assign out_o.overflowed   = slot_q[0].ovf;
  assign out_o.run_end      = slot_q[0].run_end;

endmodule

// ===== src/decimal_integer_tokenizer_unit.sv =====
// Decimal integer tokenizer top level.
// An accepted byte is held in an input register; its results are registered in the output buffer when it is processed.
// Throughput: one byte per cycle while each byte yields at most one result and the output is ready;
// a byte that yields several results holds up the next byte while they drain.
// Reset: scan state and buffers clear, comment_char = '#', line_mode = 0.
module decimal_integer_tokenizer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  dit_in_if.sink     in_i,
  dit_out_if.source  out_o,
  dit_cfg_if.sink    cfg_i
);
  import dit_pkg::*;

  logic               in_valid_q;
  logic [7:0]         text_q;
  logic               fin_q;
  scan_state_t        state_q;
  scan_state_t        state_d;
  cfg_t               cfg_q;
  result_t            res [MaxResults];
  logic [CntBits-1:0] count;
  logic               free;
  logic               fire;
  logic               in_acc;

  assign fire       = in_valid_q && ((count == '0) || free);
  assign in_i.ready = !in_valid_q || fire;
  assign in_acc     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_acc) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      text_q <= in_i.text_byte;
      fin_q  <= in_i.final_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase <= PhSeek;
      state_q.acc   <= '0;
      state_q.neg   <= 1'b0;
      state_q.ovf   <= 1'b0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.comment_char <= CommentReset;
      cfg_q.line_mode    <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgCommentChar: cfg_q.comment_char <= cfg_i.data;
        CfgLineMode:    cfg_q.line_mode    <= cfg_i.data[0];
        default:        cfg_q <= cfg_q;
      endcase
    end
  end

  dit_scan u_scan (
    .state_i      (state_q),
    .cfg_i        (cfg_q),
    .text_byte_i  (text_q),
    .final_byte_i (fin_q),
    .state_o      (state_d),
    .res_o        (res),
    .count_o      (count)
  );

  dit_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && (count != '0)),
    .count_i (count),
    .res_i   (res),
    .free_o  (free),
    .out_o   (out_o)
  );

endmodule

// ===== src/dit_checker.sv =====
// Port-level checks of the tokenizer top level and their bind.
module dit_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  kind_i,
  input logic [31:0] value_i,
  input logic        ovf_i,
  input logic        run_end_i
);
  import dit_pkg::*;

  // input only stalls while results are waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result pending");

  // more results of the same item follow at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !run_end_i) |=> out_valid_i)
    else $error("item run broken before run_end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (kind_i != KindInt)) |-> ((value_i == '0) && !ovf_i))
    else $error("non-integer result carries value or overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(kind_i) && $stable(value_i) && $stable(ovf_i)
       && $stable(run_end_i)))
    else $error("stalled result changed");

endmodule

bind decimal_integer_tokenizer_unit dit_checker u_dit_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .kind_i      (out_o.result_kind),
  .value_i     (out_o.number_value),
  .ovf_i       (out_o.overflowed),
  .run_end_i   (out_o.run_end)
);
